>>> hdl/tcp_segment_checksum_macros.svh
// Assertion macros for the TCP segment checksum block.
// Taken in by the RTL files that carry concurrent assertions; expects clk and rst in scope.
`ifndef TCP_SEGMENT_CHECKSUM_MACROS_SVH
`define TCP_SEGMENT_CHECKSUM_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define TSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/tsc_pkg.sv
// Shared types, constants and the ones' complement fold helper for the TCP segment checksum block.
// No dependencies; used by every module under hdl.
package tsc_pkg;

  localparam int MAX_PAYLOAD = 2048;
  localparam int COUNT_W     = $clog2(MAX_PAYLOAD + 1);
  localparam int SUM_W       = 19;   // room for up to eight 16-bit words

  localparam logic [15:0] HDR_LEN        = 16'd20;
  localparam logic [15:0] PROTO_TCP      = 16'd6;
  localparam logic [7:0]  DATA_OFFSET_HI = 8'h50;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_SRC_ADDR = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DST_ADDR = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_PORT = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DST_PORT = 8'd3;

  // One item after the input register, header words already summed.
  typedef struct packed {
    logic [15:0] hdr_sum;
    logic [7:0]  payload_byte;
    logic        byte_present;
    logic        first_item;
    logic        last_item;
  } tsc_item_t;

  // Fold a multi-word sum into a 16-bit end-around-carry value.
  // Zero stays zero; any nonzero sum lands in 1..0xffff.
  function automatic logic [15:0] csum_fold(input logic [SUM_W-1:0] s);
    logic [16:0] t;
    t = 17'(s[15:0]) + 17'(s[SUM_W-1:16]);
    return t[15:0] + 16'(t[16]);
  endfunction

endpackage

>>> hdl/tsc_cfg_regs.sv
// Configuration registers and the registered sum of their words and the protocol number.
// Depends on tsc_pkg.
module tsc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [tsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tsc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [15:0]                       cfg_sum
);

  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [tsc_pkg::SUM_W-1:0] raw_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_address      <= '0;
      destination_address <= '0;
      source_port         <= '0;
      destination_port    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tsc_pkg::REG_SRC_ADDR: source_address      <= cfg_data;
        tsc_pkg::REG_DST_ADDR: destination_address <= cfg_data;
        tsc_pkg::REG_SRC_PORT: source_port         <= cfg_data[15:0];
        tsc_pkg::REG_DST_PORT: destination_port    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Constant part of the pseudo header and header: addresses, protocol, ports.
  assign raw_sum = tsc_pkg::SUM_W'(source_address[31:16])
                 + tsc_pkg::SUM_W'(source_address[15:0])
                 + tsc_pkg::SUM_W'(destination_address[31:16])
                 + tsc_pkg::SUM_W'(destination_address[15:0])
                 + tsc_pkg::SUM_W'(source_port)
                 + tsc_pkg::SUM_W'(destination_port)
                 + tsc_pkg::SUM_W'(tsc_pkg::PROTO_TCP);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_sum <= '0;
    end else begin
      cfg_sum <= tsc_pkg::csum_fold(raw_sum);
    end
  end

endmodule

>>> hdl/tsc_in_stage.sv
// Input register: one transaction per cycle unless stalled; pre-sums the header words.
// Depends on tsc_pkg.
module tsc_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         sequence_number,
  input  logic [31:0]         ack_number,
  input  logic [7:0]          tcp_flags,
  input  logic [15:0]         window_size,
  input  logic [7:0]          payload_byte,
  input  logic                byte_present,
  input  logic                first_item,
  input  logic                last_item,
  output logic                item_valid,
  input  logic                item_ready,
  output tsc_pkg::tsc_item_t  item
);

  logic [tsc_pkg::SUM_W-1:0] hdr_raw;

  assign in_ready = !item_valid || item_ready;

  assign hdr_raw = tsc_pkg::SUM_W'(sequence_number[31:16])
                 + tsc_pkg::SUM_W'(sequence_number[15:0])
                 + tsc_pkg::SUM_W'(ack_number[31:16])
                 + tsc_pkg::SUM_W'(ack_number[15:0])
                 + tsc_pkg::SUM_W'({tsc_pkg::DATA_OFFSET_HI, tcp_flags})
                 + tsc_pkg::SUM_W'(window_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.hdr_sum      <= tsc_pkg::csum_fold(hdr_raw);
      item.payload_byte <= payload_byte;
      item.byte_present <= byte_present;
      item.first_item   <= first_item;
      item.last_item    <= last_item;
    end
  end

endmodule

>>> hdl/tsc_accum.sv
// Segment state update and result register for the TCP segment checksum block.
// Depends on tsc_pkg and tcp_segment_checksum_macros.svh.
`include "tcp_segment_checksum_macros.svh"

module tsc_accum (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  tsc_pkg::tsc_item_t                item,
  input  logic [15:0]                       cfg_sum,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [15:0]                       checksum,
  output logic [tsc_pkg::COUNT_W-1:0]       payload_length,
  output logic                              too_long
);

  logic [15:0]                 running_sum;
  logic [7:0]                  held_high_byte;
  logic                        odd_position;
  logic [tsc_pkg::COUNT_W-1:0] byte_count;
  logic                        overflow_seen;

  logic [15:0]                 base_sum;
  logic [7:0]                  base_held;
  logic                        base_odd;
  logic [tsc_pkg::COUNT_W-1:0] base_count;
  logic                        base_ovf;
  logic [15:0]                 hdr_word;
  logic                        take;
  logic [15:0]                 pair_word;
  logic [15:0]                 tail_word;
  logic [15:0]                 len_word;
  logic [15:0]                 running_sum_next;
  logic [7:0]                  held_high_byte_next;
  logic                        odd_position_next;
  logic [tsc_pkg::COUNT_W-1:0] byte_count_next;
  logic                        overflow_seen_next;
  logic [15:0]                 end_sum;
  logic                        advance;

  assign item_ready = !item.last_item || !out_valid || out_ready;
  assign advance    = item_valid && item_ready;

  always_comb begin
    // A start drops whatever segment was running.
    base_sum   = item.first_item ? 16'd0 : running_sum;
    base_held  = item.first_item ? 8'd0 : held_high_byte;
    base_odd   = item.first_item ? 1'b0 : odd_position;
    base_count = item.first_item ? '0 : byte_count;
    base_ovf   = item.first_item ? 1'b0 : overflow_seen;
    hdr_word   = item.first_item ? item.hdr_sum : 16'd0;

    take = item.byte_present && (base_count < tsc_pkg::COUNT_W'(tsc_pkg::MAX_PAYLOAD));
    pair_word = (take && base_odd) ? {base_held, item.payload_byte} : 16'd0;

    overflow_seen_next  = base_ovf || (item.byte_present && !take);
    byte_count_next     = take ? base_count + 1'b1 : base_count;
    odd_position_next   = take ? !base_odd : base_odd;
    held_high_byte_next = take ? (base_odd ? 8'd0 : item.payload_byte) : base_held;

    running_sum_next = tsc_pkg::csum_fold(tsc_pkg::SUM_W'(base_sum)
                                        + tsc_pkg::SUM_W'(hdr_word)
                                        + tsc_pkg::SUM_W'(pair_word));

    // Pad an odd final byte, then add the constant words and the TCP length.
    tail_word = odd_position_next ? {held_high_byte_next, 8'd0} : 16'd0;
    len_word  = tsc_pkg::HDR_LEN + 16'(byte_count_next);
    end_sum   = tsc_pkg::csum_fold(tsc_pkg::SUM_W'(base_sum)
                                 + tsc_pkg::SUM_W'(hdr_word)
                                 + tsc_pkg::SUM_W'(pair_word)
                                 + tsc_pkg::SUM_W'(tail_word)
                                 + tsc_pkg::SUM_W'(cfg_sum)
                                 + tsc_pkg::SUM_W'(len_word));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      held_high_byte <= '0;
      odd_position   <= 1'b0;
      byte_count     <= '0;
      overflow_seen  <= 1'b0;
    end else if (advance) begin
      if (item.last_item) begin
        running_sum    <= '0;
        held_high_byte <= '0;
        odd_position   <= 1'b0;
        byte_count     <= '0;
        overflow_seen  <= 1'b0;
      end else begin
        running_sum    <= running_sum_next;
        held_high_byte <= held_high_byte_next;
        odd_position   <= odd_position_next;
        byte_count     <= byte_count_next;
        overflow_seen  <= overflow_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && item.last_item) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last_item) begin
      checksum       <= ~end_sum;
      payload_length <= byte_count_next;
      too_long       <= overflow_seen_next;
    end
  end

  `TSC_ASSERT_ALWAYS(a_parity, odd_position == byte_count[0], "held byte out of step with count")
  `TSC_ASSERT_ALWAYS(a_ovf_full, !overflow_seen || (byte_count == tsc_pkg::COUNT_W'(tsc_pkg::MAX_PAYLOAD)), "overflow flagged before count is full")
  `TSC_ASSERT_NEXT(a_result, advance && item.last_item, out_valid, "last transaction gave no result")
  `TSC_ASSERT_NEXT(a_clear, advance && item.last_item, (running_sum == 16'd0) && (byte_count == '0) && !overflow_seen, "segment state not cleared after end")

endmodule

>>> hdl/tcp_segment_checksum.sv
// Top level of the TCP segment checksum block.
// Depends on tsc_pkg, tsc_cfg_regs, tsc_in_stage and tsc_accum.
//
// Computes the TCP checksum of one segment over the IPv4 pseudo header, a 20-byte
// option-less TCP header and the payload, which arrives one byte per input transaction.
// A transaction with first_item set samples sequence_number, ack_number, tcp_flags and
// window_size and restarts the sum (dropping any segment in progress); byte_present
// marks a valid payload_byte; last_item closes the segment and yields exactly one
// result transaction with the complemented sum (high byte goes first on the wire),
// the payload byte count and a too_long flag. Bytes beyond 2048 are not summed and
// set too_long. Bytes pair big-endian; an odd last byte is padded with zero.
// Rate: one input transaction per clock, sustained across segment ends unless stalled.
// The last_item transaction is first loaded into the input register, where the sampled
// header words are pre-summed; the state update stage then loads the result register
// and raises out_valid. The only stall is a last_item transaction meeting a full
// result register whose result is not being taken; out_ready then reaches in_ready
// through the input register's ready logic in the same cycle.
// Configuration registers (0 source_address, 1 destination_address, 2 source_port,
// 3 destination_port) are written with cfg_write; indexes beyond 3 are ignored.
// Their values are folded into a registered sum and used when a segment ends, so
// write them while the block is idle.
module tcp_segment_checksum (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_write,
  input  logic [tsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tsc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [31:0]                       sequence_number,
  input  logic [31:0]                       ack_number,
  input  logic [7:0]                        tcp_flags,
  input  logic [15:0]                       window_size,
  input  logic [7:0]                        payload_byte,
  input  logic                              byte_present,
  input  logic                              first_item,
  input  logic                              last_item,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [15:0]                       checksum,
  output logic [tsc_pkg::COUNT_W-1:0]       payload_length,
  output logic                              too_long
);

  logic               item_valid;
  logic               item_ready;
  tsc_pkg::tsc_item_t item;
  logic [15:0]        cfg_sum;

  // Hold the address and port words as one precomputed partial sum.
  tsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_sum   (cfg_sum)
  );

  // Register each accepted transaction; sum its header words on the way in.
  tsc_in_stage u_in (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sequence_number (sequence_number),
    .ack_number      (ack_number),
    .tcp_flags       (tcp_flags),
    .window_size     (window_size),
    .payload_byte    (payload_byte),
    .byte_present    (byte_present),
    .first_item      (first_item),
    .last_item       (last_item),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .item            (item)
  );

  // Advance the segment state and load the result register at segment end.
  tsc_accum u_accum (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .cfg_sum        (cfg_sum),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .checksum       (checksum),
    .payload_length (payload_length),
    .too_long       (too_long)
  );

endmodule
